// ----- rtl/psb_pkg.sv -----
// Package with the shared constants, codes and types of the palette sprite blitter.
`default_nettype none

package psb_pkg;

    localparam int TEX_BYTES       = 4096;
    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_SIDE        = 8;

    localparam int TEX_AW = $clog2(TEX_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    localparam logic [7:0] ALPHA_MIN = 8'h7f;

    localparam logic [1:0] FUNC_TEX  = 2'd0;
    localparam logic [1:0] FUNC_PAL  = 2'd1;
    localparam logic [1:0] FUNC_DRAW = 2'd2;

    localparam logic [1:0] CFG_BITS_LOG2 = 2'd0;
    localparam logic [1:0] CFG_TEX_WIDTH = 2'd1;
    localparam logic [1:0] CFG_TEX_BYTES = 2'd2;
    localparam logic [1:0] CFG_PAL_COUNT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } psb_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] addr;
        logic [15:0] data;
        logic [7:0]  entry_alpha;
        logic [7:0]  src_x;
        logic [7:0]  src_y;
        logic [3:0]  rect_w;
        logic [3:0]  rect_h;
        logic [15:0] dst_x;
        logic [15:0] dst_y;
        logic        use_tint;
    } psb_req_t;

    typedef struct packed {
        logic accept;
        logic walk;
    } psb_cmd_t;

    typedef struct packed {
        logic draw_start;
        logic last_issue;
        logic pipe_empty;
    } psb_sts_t;

endpackage

`default_nettype wire

// ----- rtl/psb_in_if.sv -----
// Request channel interface of the palette sprite blitter.
`default_nettype none

interface psb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] addr;
    logic [15:0] data;
    logic [7:0]  entry_alpha;
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [3:0]  rect_w;
    logic [3:0]  rect_h;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic        use_tint;

    modport source (
        output valid, func, addr, data, entry_alpha, src_x, src_y,
               rect_w, rect_h, dst_x, dst_y, use_tint,
        input  ready
    );

    modport sink (
        input  valid, func, addr, data, entry_alpha, src_x, src_y,
               rect_w, rect_h, dst_x, dst_y, use_tint,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/psb_out_if.sv -----
// Pixel result channel interface of the palette sprite blitter.
`default_nettype none

interface psb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] colour;
    logic        write_enable;
    logic        last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, colour, write_enable, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, colour, write_enable, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/psb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module psb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psb_ctrl.sv -----
// Controller state machine that sequences loads, the texel walk and the pipeline drain.
`default_nettype none

module psb_ctrl
    import psb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire psb_sts_t sts,
    output logic          req_ready,
    output psb_cmd_t      cmd
);

    psb_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && sts.draw_start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.accept = 1'b0;
        cmd.walk   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/psb_dp.sv -----
// Datapath with configuration registers, stores, texel walk counters and lookup pipeline.
`default_nettype none

module psb_dp
    import psb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire psb_req_t    req,
    input  wire psb_cmd_t    cmd,
    output psb_sts_t         sts,
    psb_out_if.source        rsp
);

    logic [1:0]  bits_log2_reg;
    logic [8:0]  tex_width_reg;
    logic [12:0] tex_bytes_reg;
    logic [8:0]  pal_count_reg;

    logic [CNT_W-1:0] cx_reg, cy_reg, wm1_reg, hm1_reg;
    logic [7:0]       sx_reg, sy_reg;
    logic [15:0]      dx_reg, dy_reg, tint_reg;
    logic             use_tint_reg;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [17:0]      s1_prod_reg;
    logic [8:0]       s1_col_reg;
    logic [15:0]      s1_px_reg, s2_px_reg, s3_px_reg;
    logic [15:0]      s1_py_reg, s2_py_reg, s3_py_reg;
    logic             s1_last_reg, s2_last_reg, s3_last_reg;
    logic             s2_in_range_reg;
    logic [2:0]       s2_shift_reg;
    logic             s3_idx_ok_reg;

    logic             out_valid_reg;
    logic [15:0]      out_x_reg, out_y_reg, out_colour_reg;
    logic             out_we_reg, out_last_reg;

    logic             adv;
    logic             issue;
    logic             at_end;
    logic [3:0]       w_sat, h_sat;
    logic [8:0]       ypos, xcol;
    logic [18:0]      tex_i, byte_i;
    logic [12:0]      tex_lim;
    logic [8:0]       pal_lim;
    logic [2:0]       pos_mask;
    logic [2:0]       shift;
    logic [3:0]       bits;
    logic [8:0]       one_hot;
    logic [7:0]       tex_mask;
    logic [7:0]       tex_rdata;
    logic [7:0]       idx;
    logic [23:0]      pal_rdata;
    logic             opaque;
    logic             tex_we, pal_we;

    assign adv    = !out_valid_reg || rsp.ready;
    assign issue  = cmd.walk && adv;
    assign at_end = (cx_reg == wm1_reg) && (cy_reg == hm1_reg);

    assign w_sat = (req.rect_w > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : req.rect_w;
    assign h_sat = (req.rect_h > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : req.rect_h;

    assign sts.draw_start = (req.func == FUNC_DRAW) && (req.rect_w != 4'd0)
                            && (req.rect_h != 4'd0);
    assign sts.last_issue = issue && at_end;
    assign sts.pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_log2_reg <= 2'd2;
            tex_width_reg <= 9'd8;
            tex_bytes_reg <= 13'd0;
            pal_count_reg <= 9'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BITS_LOG2: bits_log2_reg <= cfg_data[1:0];
                CFG_TEX_WIDTH: tex_width_reg <= cfg_data[8:0];
                CFG_TEX_BYTES: tex_bytes_reg <= cfg_data;
                CFG_PAL_COUNT: pal_count_reg <= cfg_data[8:0];
                default:       bits_log2_reg <= bits_log2_reg;
            endcase
        end
    end

    assign tex_we = cmd.accept && (req.func == FUNC_TEX) && (32'(req.addr) < TEX_BYTES);
    assign pal_we = cmd.accept && (req.func == FUNC_PAL)
                    && (32'(req.addr) < PALETTE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (cmd.accept && sts.draw_start)
        begin
            wm1_reg      <= CNT_W'(w_sat - 4'd1);
            hm1_reg      <= CNT_W'(h_sat - 4'd1);
            sx_reg       <= req.src_x;
            sy_reg       <= req.src_y;
            dx_reg       <= req.dst_x;
            dy_reg       <= req.dst_y;
            tint_reg     <= req.data;
            use_tint_reg <= req.use_tint;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cmd.accept)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (issue)
        begin
            if (cy_reg == hm1_reg)
            begin
                cy_reg <= '0;
                cx_reg <= cx_reg + 1'b1;
            end
            else
            begin
                cy_reg <= cy_reg + 1'b1;
            end
        end
    end

    // Stage one: row times texture width, column position and destination.
    assign ypos = 9'(sy_reg) + 9'(cy_reg);
    assign xcol = 9'(sx_reg) + 9'(cx_reg);

    // Stage two: texel index, byte address, range check and bit position.
    assign tex_i    = 19'(s1_prod_reg) + 19'(s1_col_reg);
    assign byte_i   = tex_i >> (2'd3 - bits_log2_reg);
    assign tex_lim  = (tex_bytes_reg > 13'(TEX_BYTES)) ? 13'(TEX_BYTES) : tex_bytes_reg;
    assign pos_mask = 3'd7 >> bits_log2_reg;
    assign shift    = (pos_mask - (tex_i[2:0] & pos_mask)) << bits_log2_reg;

    // Stage three: texel index out of the byte and palette range check.
    assign bits     = 4'd1 << bits_log2_reg;
    assign one_hot  = 9'd1 << bits;
    assign tex_mask = 8'(one_hot - 9'd1);
    assign idx      = (tex_rdata >> s2_shift_reg) & tex_mask;
    assign pal_lim  = (pal_count_reg > 9'(PALETTE_ENTRIES)) ? 9'(PALETTE_ENTRIES)
                                                           : pal_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg     <= ypos * tex_width_reg;
            s1_col_reg      <= xcol;
            s1_px_reg       <= dx_reg + 16'(cx_reg);
            s1_py_reg       <= dy_reg + 16'(cy_reg);
            s1_last_reg     <= at_end;

            s2_in_range_reg <= byte_i < 19'(tex_lim);
            s2_shift_reg    <= shift;
            s2_px_reg       <= s1_px_reg;
            s2_py_reg       <= s1_py_reg;
            s2_last_reg     <= s1_last_reg;

            s3_idx_ok_reg   <= s2_in_range_reg && (9'(idx) < pal_lim);
            s3_px_reg       <= s2_px_reg;
            s3_py_reg       <= s2_py_reg;
            s3_last_reg     <= s2_last_reg;

            out_x_reg       <= s3_px_reg;
            out_y_reg       <= s3_py_reg;
            out_we_reg      <= opaque;
            out_last_reg    <= s3_last_reg;
            out_colour_reg  <= !opaque ? 16'd0 : (use_tint_reg ? tint_reg : pal_rdata[23:8]);
        end
    end

    assign opaque = s3_idx_ok_reg && (pal_rdata[7:0] >= ALPHA_MIN);

    psb_ram #(
        .WIDTH (8),
        .DEPTH (TEX_BYTES)
    ) u_tex_ram (
        .clk   (clk),
        .we    (tex_we),
        .waddr (req.addr[TEX_AW-1:0]),
        .wdata (req.data[7:0]),
        .re    (adv),
        .raddr (byte_i[TEX_AW-1:0]),
        .rdata (tex_rdata)
    );

    psb_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (req.addr[PAL_AW-1:0]),
        .wdata ({req.data, req.entry_alpha}),
        .re    (adv),
        .raddr (idx[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.pixel_x      = out_x_reg;
    assign rsp.pixel_y      = out_y_reg;
    assign rsp.colour       = out_colour_reg;
    assign rsp.write_enable = out_we_reg;
    assign rsp.last_pixel   = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/palette_sprite_blitter.sv -----
// Top level of the palette sprite blitter: controller, datapath and checks.
//
// Channel   Direction  Transfer moves
// req       sink       one load or draw command
// rsp       source     one destination pixel of a draw
// cfg       write      one configuration register
//
// A load is one transfer. A draw of W by H texels keeps the request side closed until
// its texels have left the lookup stages, walking one texel a cycle while results are taken
// through a four-stage pipeline set by the texture and palette memory read ports.
// Reset clears control state only; the stores need no clearing pass.
// A result that is not taken stalls the whole pipeline and the texel walk.
`default_nettype none

module palette_sprite_blitter
    import psb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    psb_in_if.sink           req,
    psb_out_if.source        rsp
);

    psb_req_t req_payload;
    psb_cmd_t cmd;
    psb_sts_t sts;

    assign req_payload.func        = req.func;
    assign req_payload.addr        = req.addr;
    assign req_payload.data        = req.data;
    assign req_payload.entry_alpha = req.entry_alpha;
    assign req_payload.src_x       = req.src_x;
    assign req_payload.src_y       = req.src_y;
    assign req_payload.rect_w      = req.rect_w;
    assign req_payload.rect_h      = req.rect_h;
    assign req_payload.dst_x       = req.dst_x;
    assign req_payload.dst_y       = req.dst_y;
    assign req_payload.use_tint    = req.use_tint;

    psb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (sts),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    psb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_payload),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

    // A new command is only taken with no texel left in the lookup pipeline.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> sts.pipe_empty)
        else $error("request taken while the pipeline holds texels");

    // A draw transfer closes the request side for the following cycle.
    a_draw_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && sts.draw_start) |=> !req.ready)
        else $error("request side still open after a draw transfer");

    // The walk stops right after its last texel has been issued.
    a_walk_stops: assert property (@(posedge clk) disable iff (!rst_n)
        sts.last_issue |=> !cmd.walk)
        else $error("texel walk continues after its last texel");

endmodule

`default_nettype wire

// ----- bench/palette_sprite_blitter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the palette sprite blitter with its own pixel predictor.

module palette_sprite_blitter_tb;
    import psb_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX   = 200;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 40;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] colour;
        logic        we;
        logic        last;
    } pixel_t;

    class pixel_ledger;
        logic [1:0]  bits_log2;
        logic [8:0]  tex_width;
        logic [12:0] tex_bytes;
        logic [8:0]  pal_count;
        logic [7:0]  tex_mem [TEX_BYTES];
        bit          tex_set [TEX_BYTES];
        logic [15:0] pal_colour [PALETTE_ENTRIES];
        logic [7:0]  pal_alpha [PALETTE_ENTRIES];
        bit          pal_set [PALETTE_ENTRIES];
        pixel_t      pixels_due [$];
        int          errors;
        int          reported;

        function new();
            bits_log2 = 2'd2;
            tex_width = 9'd8;
            tex_bytes = 13'd0;
            pal_count = 9'd0;
            errors    = 0;
            reported  = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [12:0] value);
            case (index)
                CFG_BITS_LOG2: bits_log2 = value[1:0];
                CFG_TEX_WIDTH: tex_width = value[8:0];
                CFG_TEX_BYTES: tex_bytes = value;
                CFG_PAL_COUNT: pal_count = value[8:0];
                default: ;
            endcase
        endfunction

        function int unsigned side(logic [3:0] n);
            return (n > MAX_SIDE) ? MAX_SIDE : n;
        endfunction

        function int unsigned texel_number(logic [7:0] sx, logic [7:0] sy,
                                           int unsigned cx, int unsigned cy);
            return (sy + cy) * tex_width + sx + cx;
        endfunction

        function int unsigned byte_of(int unsigned texel);
            return texel >> (3 - bits_log2);
        endfunction

        function int unsigned byte_limit();
            return (tex_bytes < TEX_BYTES) ? tex_bytes : TEX_BYTES;
        endfunction

        function int unsigned pal_limit();
            return (pal_count < PALETTE_ENTRIES) ? pal_count : PALETTE_ENTRIES;
        endfunction

        function int unsigned index_of(int unsigned texel);
            int unsigned bits;
            int unsigned per_byte;
            int unsigned shift;
            bits     = 1 << bits_log2;
            per_byte = 8 >> bits_log2;
            shift    = (per_byte - 1 - (texel & (per_byte - 1))) * bits;
            return (tex_mem[byte_of(texel)] >> shift) & ((1 << bits) - 1);
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void take_request(psb_req_t r);
            int unsigned w;
            int unsigned h;
            int unsigned texel;
            int unsigned idx;
            pixel_t p;
            case (r.func)
                FUNC_TEX:
                begin
                    tex_mem[r.addr] = r.data[7:0];
                    tex_set[r.addr] = 1'b1;
                end
                FUNC_PAL:
                begin
                    if (r.addr < PALETTE_ENTRIES)
                    begin
                        pal_colour[r.addr] = r.data;
                        pal_alpha[r.addr]  = r.entry_alpha;
                        pal_set[r.addr]    = 1'b1;
                    end
                end
                FUNC_DRAW:
                begin
                    w = side(r.rect_w);
                    h = side(r.rect_h);
                    for (int unsigned cx = 0; cx < w; cx++)
                    begin
                        for (int unsigned cy = 0; cy < h; cy++)
                        begin
                            texel    = texel_number(r.src_x, r.src_y, cx, cy);
                            p.x      = 16'(r.dst_x + cx);
                            p.y      = 16'(r.dst_y + cy);
                            p.we     = 1'b0;
                            p.colour = 16'h0000;
                            if (byte_of(texel) < byte_limit())
                            begin
                                idx = index_of(texel);
                                if (idx < pal_limit() && pal_alpha[idx] >= ALPHA_MIN)
                                begin
                                    p.we     = 1'b1;
                                    p.colour = r.use_tint ? r.data : pal_colour[idx];
                                end
                            end
                            p.last = (cx + 1 == w) && (cy + 1 == h);
                            pixels_due.push_back(p);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                if (reported < REPORT_MAX)
                    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                reported++;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixels_due.size() == 0)
            begin
                errors++;
                if (reported < REPORT_MAX)
                    $display("%0t: pixel transfer with none expected, expected none actual %h",
                             $time, got);
                reported++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("pixel_x", want.x, got.x);
                check_field("pixel_y", want.y, got.y);
                check_field("colour", want.colour, got.colour);
                check_field("write_enable", 16'(want.we), 16'(got.we));
                check_field("last_pixel", 16'(want.last), 16'(got.last));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    bit          calm;
    bit          hold_req;
    int          cycles = 0;
    int          sent_items = 0;
    pixel_ledger ledger;

    psb_in_if  req_ch ();
    psb_out_if rsp_ch ();

    palette_sprite_blitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("palette_sprite_blitter_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.x      = rsp_ch.pixel_x;
            got.y      = rsp_ch.pixel_y;
            got.colour = rsp_ch.colour;
            got.we     = rsp_ch.write_enable;
            got.last   = rsp_ch.last_pixel;
            ledger.check_pixel(got);
        end
    end

    initial
    begin : pixel_sink
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    function automatic psb_req_t rand_request();
        psb_req_t r;
        r.func        = 2'($urandom);
        r.addr        = 12'($urandom);
        r.data        = 16'($urandom);
        r.entry_alpha = 8'($urandom);
        r.src_x       = 8'($urandom);
        r.src_y       = 8'($urandom);
        r.rect_w      = 4'($urandom);
        r.rect_h      = 4'($urandom);
        r.dst_x       = 16'($urandom);
        r.dst_y       = 16'($urandom);
        r.use_tint    = 1'($urandom);
        return r;
    endfunction

    task automatic send(psb_req_t r);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= r.func;
        req_ch.addr        <= r.addr;
        req_ch.data        <= r.data;
        req_ch.entry_alpha <= r.entry_alpha;
        req_ch.src_x       <= r.src_x;
        req_ch.src_y       <= r.src_y;
        req_ch.rect_w      <= r.rect_w;
        req_ch.rect_h      <= r.rect_h;
        req_ch.dst_x       <= r.dst_x;
        req_ch.dst_y       <= r.dst_y;
        req_ch.use_tint    <= r.use_tint;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sent_items++;
        ledger.take_request(r);
    endtask

    // Every texture byte and palette entry that a draw will look at is loaded first.
    task automatic prime_stores(psb_req_t d);
        psb_req_t    ld;
        int unsigned texel;
        int unsigned byte_i;
        int unsigned idx;
        for (int unsigned cx = 0; cx < ledger.side(d.rect_w); cx++)
        begin
            for (int unsigned cy = 0; cy < ledger.side(d.rect_h); cy++)
            begin
                texel  = ledger.texel_number(d.src_x, d.src_y, cx, cy);
                byte_i = ledger.byte_of(texel);
                if (byte_i < ledger.byte_limit())
                begin
                    if (!ledger.tex_set[byte_i])
                    begin
                        ld      = rand_request();
                        ld.func = FUNC_TEX;
                        ld.addr = 12'(byte_i);
                        send(ld);
                    end
                    idx = ledger.index_of(texel);
                    if (!ledger.pal_set[idx])
                    begin
                        ld      = rand_request();
                        ld.func = FUNC_PAL;
                        ld.addr = 12'(idx);
                        send(ld);
                    end
                end
            end
        end
    endtask

    task automatic load_texture(logic [11:0] addr, logic [15:0] data);
        psb_req_t r;
        r      = rand_request();
        r.func = FUNC_TEX;
        r.addr = addr;
        r.data = data;
        send(r);
    endtask

    task automatic load_palette(logic [11:0] addr, logic [15:0] colour, logic [7:0] alpha);
        psb_req_t r;
        r             = rand_request();
        r.func        = FUNC_PAL;
        r.addr        = addr;
        r.data        = colour;
        r.entry_alpha = alpha;
        send(r);
    endtask

    task automatic blit_rect(logic [7:0] sx, logic [7:0] sy, logic [3:0] w, logic [3:0] h,
                             logic [15:0] dx, logic [15:0] dy, logic tint,
                             logic [15:0] tint_colour);
        psb_req_t r;
        r          = rand_request();
        r.func     = FUNC_DRAW;
        r.src_x    = sx;
        r.src_y    = sy;
        r.rect_w   = w;
        r.rect_h   = h;
        r.dst_x    = dx;
        r.dst_y    = dy;
        r.use_tint = tint;
        r.data     = tint_colour;
        prime_stores(r);
        send(r);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        ledger.set_reg(index, value);
    endtask

    task automatic configure(logic [1:0] bits, logic [8:0] width, logic [12:0] nbytes,
                             logic [8:0] count);
        settle();
        write_reg(CFG_BITS_LOG2, 13'(bits));
        write_reg(CFG_TEX_WIDTH, 13'(width));
        write_reg(CFG_TEX_BYTES, nbytes);
        write_reg(CFG_PAL_COUNT, 13'(count));
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [1:0]  bits;
        logic [8:0]  width;
        logic [12:0] nbytes;
        logic [8:0]  count;
        bits = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0: width = 9'd0;
            1: width = 9'd1;
            2: width = 9'd256;
            3: width = 9'd511;
            default: width = 9'($urandom_range(1, 32));
        endcase
        case ($urandom_range(0, 5))
            0: nbytes = 13'd0;
            1: nbytes = 13'd4096;
            2: nbytes = 13'd8191;
            3: nbytes = 13'($urandom_range(0, 8191));
            default: nbytes = 13'($urandom_range(1, 128));
        endcase
        case ($urandom_range(0, 5))
            0: count = 9'd0;
            1: count = 9'd256;
            2: count = 9'd511;
            3: count = 9'($urandom_range(0, 511));
            default: count = 9'($urandom_range(1, 1 << (1 << bits)));
        endcase
        configure(bits, width, nbytes, count);
    endtask

    task automatic random_item();
        psb_req_t    r;
        int unsigned pick;
        r    = rand_request();
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.func = FUNC_DRAW;
            case ($urandom_range(0, 9))
                0:
                begin
                    r.rect_w = 4'($urandom);
                    r.rect_h = 4'($urandom);
                end
                1, 2:
                begin
                    r.rect_w = 4'($urandom_range(5, 8));
                    r.rect_h = 4'($urandom_range(5, 8));
                end
                default:
                begin
                    r.rect_w = 4'($urandom_range(1, 4));
                    r.rect_h = 4'($urandom_range(1, 4));
                end
            endcase
            if ($urandom_range(0, 9) < 7)
            begin
                r.src_x = 8'($urandom_range(0, 15));
                r.src_y = 8'($urandom_range(0, 7));
            end
            prime_stores(r);
        end
        else if (pick < 75)
        begin
            r.func = FUNC_TEX;
            if ($urandom_range(0, 9) < 7)
                r.addr = 12'($urandom_range(0, 63));
        end
        else if (pick < 95)
        begin
            r.func = FUNC_PAL;
            if ($urandom_range(0, 4) != 0)
                r.addr = 12'($urandom_range(0, 255));
        end
        else
        begin
            r.func = FUNC_NONE;
        end
        send(r);
    endtask

    initial
    begin : stimulus
        psb_req_t r;
        ledger   = new();
        calm     = 1'b0;
        hold_req = 1'b0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_BITS_LOG2;
        cfg_data           <= 13'd0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_TEX;
        req_ch.addr        <= 12'd0;
        req_ch.data        <= 16'd0;
        req_ch.entry_alpha <= 8'd0;
        req_ch.src_x       <= 8'd0;
        req_ch.src_y       <= 8'd0;
        req_ch.rect_w      <= 4'd0;
        req_ch.rect_h      <= 4'd0;
        req_ch.dst_x       <= 16'd0;
        req_ch.dst_y       <= 16'd0;
        req_ch.use_tint    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no texture bytes are valid, so nothing is written.
        blit_rect(8'd0, 8'd0, 4'd2, 4'd2, 16'd0, 16'd0, 1'b1, 16'hffff);
        r      = rand_request();
        r.func = FUNC_NONE;
        send(r);
        load_palette(12'hfff, 16'hffff, 8'hff);

        configure(2'd0, 9'd8, 13'd16, 9'd2);
        load_palette(12'd0, 16'h0000, 8'h7f);
        load_palette(12'd1, 16'hffff, 8'h7e);
        load_texture(12'd0, 16'hffa5);
        blit_rect(8'd0, 8'd0, 4'd15, 4'd15, 16'hfffc, 16'hfffd, 1'b0, 16'h0000);
        blit_rect(8'd3, 8'd3, 4'd0, 4'd5, 16'h0010, 16'h0020, 1'b0, 16'h0000);
        blit_rect(8'd3, 8'd3, 4'd5, 4'd0, 16'h0010, 16'h0020, 1'b1, 16'h1111);
        load_palette(12'd1, 16'h1234, 8'hff);
        blit_rect(8'd0, 8'd0, 4'd8, 4'd8, 16'hffff, 16'hffff, 1'b1, 16'hbeef);

        configure(2'd3, 9'd0, 13'd8191, 9'd511);
        blit_rect(8'd250, 8'd255, 4'd4, 4'd3, 16'h8000, 16'h7fff, 1'b0, 16'h0000);
        blit_rect(8'd255, 8'd0, 4'd2, 4'd2, 16'h0000, 16'h0000, 1'b1, 16'h5555);

        configure(2'd1, 9'd256, 13'd4096, 9'd256);
        load_texture(12'hfff, 16'h5a3c);
        blit_rect(8'd252, 8'd63, 4'd4, 4'd1, 16'h0100, 16'h0200, 1'b1, 16'haaaa);
        blit_rect(8'd255, 8'd255, 4'd8, 4'd8, 16'h1234, 16'h4321, 1'b0, 16'h0000);
        load_palette(12'd256, 16'h8001, 8'h80);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == PHASES - 1)
                calm = 1'b1;
            random_config();
            if (phase == 2)
                hold_req = 1'b1;
            while (sent_items < (phase + 1) * PHASE_ITEMS)
                random_item();
        end

        settle();
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("palette_sprite_blitter_tb: PASS");
        else
            $display("palette_sprite_blitter_tb: FAIL");
        $finish;
    end

endmodule
